@@ hdl/msss_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multi-stack shared store: command codes, the output width and the result
// constants for a failed pop and for a push. No dependencies.
package msss_pkg;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam int OUT_WIDTH = 32;

	localparam logic signed [OUT_WIDTH-1:0] POP_EMPTY = -32'sd1;
	localparam logic signed [OUT_WIDTH-1:0] PUSH_VALUE_OUT = 32'sd0;

endpackage

@@ hdl/msss_top_ram.sv @@
`timescale 1ns / 1ps
// Top pointer memory: one entry per stack, synchronous read into a data register.
// Per-entry valid bits make unwritten entries read as the null pointer. No dependencies.
module msss_top_ram #(
	parameter int NUM_STACKS = 4,
	parameter int TOP_W = 2,
	parameter int PTR_W = 7,
	parameter int NULL_PTR = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [TOP_W-1:0] rd_addr,
	output logic [PTR_W-1:0] rd_top,
	input  logic             wr_en,
	input  logic [TOP_W-1:0] wr_addr,
	input  logic [PTR_W-1:0] wr_top
);

	logic [PTR_W-1:0]      mem [NUM_STACKS];
	logic [NUM_STACKS-1:0] vld_q;
	logic [PTR_W-1:0]      rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_top;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_top = rd_vld_q ? rd_q : PTR_W'(NULL_PTR);

endmodule

@@ hdl/msss_slot_ram.sv @@
`timescale 1ns / 1ps
// Slot memory holding a link and a data word per slot, synchronous read.
// A fill count stands in for the reset of the links: slots at or above it link to the next slot.
module msss_slot_ram #(
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32,
	parameter int SLOT_W = 6,
	parameter int PTR_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [SLOT_W-1:0]     rd_addr,
	output logic [PTR_W-1:0]      rd_link,
	output logic [DATA_WIDTH-1:0] rd_value,
	input  logic                  wr_en,
	input  logic [SLOT_W-1:0]     wr_addr,
	input  logic [PTR_W-1:0]      wr_link,
	input  logic [DATA_WIDTH-1:0] wr_value
);

	logic [PTR_W+DATA_WIDTH-1:0] mem [CAPACITY];
	logic [PTR_W+DATA_WIDTH-1:0] rd_q;
	logic [PTR_W-1:0]            rd_addr_q;
	logic [PTR_W-1:0]            fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_link, wr_value};
		end
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= PTR_W'(rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && (PTR_W'(wr_addr) == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	assign rd_link  = (rd_addr_q < fill_q) ? rd_q[PTR_W+DATA_WIDTH-1:DATA_WIDTH]
	                                       : rd_addr_q + 1'b1;
	assign rd_value = rd_q[DATA_WIDTH-1:0];

endmodule

@@ hdl/multi_stack_shared_store_core.sv @@
`timescale 1ns / 1ps
// Top level of the multi-stack shared store: control sequencer and result register.
// Depends on msss_pkg, msss_top_ram and msss_slot_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | in_valid, in_stall | command, stack_id, push_value
//  output   | out_valid, out_stall | success, pop_value
//
// A push, or a pop on an empty or out-of-range stack, ends in ST_LOOK, any other pop in ST_POP;
// each waits on the top pointer memory read, and a pop that finds a top slot then waits on
// the slot memory read there. Reset is asynchronous and needs no clearing pass; the block
// accepts a transaction as soon as reset is released.
// A stalled result holds its register; the next transaction is still accepted and
// waits at its final step until the result register is free.
module multi_stack_shared_store_core
	import msss_pkg::*;
#(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [1:0]                  stack_id,
	input  logic signed [OUT_WIDTH-1:0] push_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        success,
	output logic signed [OUT_WIDTH-1:0] pop_value
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int PTR_W  = $clog2(CAPACITY + 1);
	localparam int TOP_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0]            state_q, state_d;
	logic                  cmd_q;
	logic                  sid_ok_q;
	logic [TOP_W-1:0]      sid_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [PTR_W-1:0]      free_head_q;
	logic [PTR_W-1:0]      slot_q;
	logic                  out_valid_q;
	logic                  success_q;
	logic [OUT_WIDTH-1:0]  pop_value_q;

	logic                  accept;
	logic                  sid_ok_in;
	logic                  head_null;
	logic                  top_null;
	logic                  out_free;
	logic                  done;
	logic                  done_ok;
	logic [OUT_WIDTH-1:0]  done_value;

	logic                  top_rd_en;
	logic [PTR_W-1:0]      top_rd;
	logic                  top_wr_en;
	logic [PTR_W-1:0]      top_wr;

	logic                  slot_rd_en;
	logic [SLOT_W-1:0]     slot_rd_addr;
	logic [PTR_W-1:0]      slot_link;
	logic [DATA_WIDTH-1:0] slot_value;
	logic signed [DATA_WIDTH-1:0] slot_value_s;
	logic                  slot_wr_en;
	logic [SLOT_W-1:0]     slot_wr_addr;
	logic [PTR_W-1:0]      slot_wr_link;
	logic [DATA_WIDTH-1:0] slot_wr_value;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign sid_ok_in = (32'(stack_id) < NUM_STACKS);
	assign head_null = (free_head_q >= PTR_W'(CAPACITY));
	assign top_null  = (top_rd >= PTR_W'(CAPACITY));
	assign out_free  = !out_valid_q || !out_stall;
	assign slot_value_s = slot_value;

	msss_top_ram #(
		.NUM_STACKS(NUM_STACKS),
		.TOP_W(TOP_W),
		.PTR_W(PTR_W),
		.NULL_PTR(CAPACITY)
	) u_top_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(top_rd_en),
		.rd_addr(TOP_W'(stack_id)),
		.rd_top(top_rd),
		.wr_en(top_wr_en),
		.wr_addr(sid_q),
		.wr_top(top_wr)
	);

	msss_slot_ram #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.SLOT_W(SLOT_W),
		.PTR_W(PTR_W)
	) u_slot_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(slot_rd_en),
		.rd_addr(slot_rd_addr),
		.rd_link(slot_link),
		.rd_value(slot_value),
		.wr_en(slot_wr_en),
		.wr_addr(slot_wr_addr),
		.wr_link(slot_wr_link),
		.wr_value(slot_wr_value)
	);

	always_comb begin
		state_d       = state_q;
		top_rd_en     = 1'b0;
		top_wr_en     = 1'b0;
		top_wr        = slot_link;
		slot_rd_en    = 1'b0;
		slot_rd_addr  = free_head_q[SLOT_W-1:0];
		slot_wr_en    = 1'b0;
		slot_wr_addr  = free_head_q[SLOT_W-1:0];
		slot_wr_link  = top_rd;
		slot_wr_value = value_q;
		done          = 1'b0;
		done_ok       = 1'b0;
		done_value    = PUSH_VALUE_OUT;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					top_rd_en  = sid_ok_in;
					slot_rd_en = sid_ok_in && (command == CMD_PUSH) && !head_null;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (cmd_q == CMD_PUSH) begin
					if (out_free) begin
						done    = 1'b1;
						done_ok = sid_ok_q && !head_null;
						state_d = ST_IDLE;
						if (done_ok) begin
							slot_wr_en = 1'b1;
							top_wr_en  = 1'b1;
							top_wr     = free_head_q;
						end
					end
				end else if (!sid_ok_q || top_null) begin
					if (out_free) begin
						done       = 1'b1;
						done_value = POP_EMPTY;
						state_d    = ST_IDLE;
					end
				end else begin
					slot_rd_en   = 1'b1;
					slot_rd_addr = top_rd[SLOT_W-1:0];
					state_d      = ST_POP;
				end
			end
			ST_POP: begin
				if (out_free) begin
					done          = 1'b1;
					done_ok       = 1'b1;
					done_value    = OUT_WIDTH'(slot_value_s);
					top_wr_en     = 1'b1;
					top_wr        = slot_link;
					slot_wr_en    = 1'b1;
					slot_wr_addr  = slot_q[SLOT_W-1:0];
					slot_wr_link  = free_head_q;
					slot_wr_value = slot_value;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_LOOK && cmd_q == CMD_PUSH && done_ok) begin
				free_head_q <= slot_link;
			end else if (state_q == ST_POP && done) begin
				free_head_q <= slot_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			sid_ok_q <= sid_ok_in;
			sid_q    <= TOP_W'(stack_id);
			value_q  <= DATA_WIDTH'(push_value);
		end
		if (slot_rd_en && state_q == ST_LOOK) begin
			slot_q <= top_rd;
		end
		if (done) begin
			success_q   <= done_ok;
			pop_value_q <= done_value;
		end
	end

	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign pop_value = pop_value_q;

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q != ST_IDLE))
		else $error("result appeared without a transaction in progress");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= PTR_W'(CAPACITY))
		else $error("free list head beyond the null pointer");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !success_q |-> (pop_value_q == PUSH_VALUE_OUT || pop_value_q == POP_EMPTY))
		else $error("failed transaction carries a data value");

	a_pop_wait_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) && out_valid_q && out_stall |=> (state_q == ST_POP))
		else $error("pop completed while the result register was held");

endmodule
